[rtl/obef_pkg.sv]
`default_nettype none

package obef_pkg;

  // Axis register layout: three signed components of 16 bits each
  localparam int AXIS_COMP_WIDTH = 16;
  localparam int AXIS_REG_WIDTH  = 48;
  localparam int NUM_AXES        = 3;

  // Result field widths
  localparam int EXTENT_WIDTH = 30;
  localparam int CENTER_WIDTH = 32;
  localparam logic [EXTENT_WIDTH-1:0] EXTENT_MAX = 30'h3FFF_FFFF;

  // Configuration register indexes
  localparam int CFG_INDEX_WIDTH = 2;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_AXIS_ONE   = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_AXIS_TWO   = 2'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_AXIS_THREE = 2'd2;

  // Reset axes: unit vectors along x, y and z
  localparam logic [AXIS_REG_WIDTH-1:0] AXIS_ONE_RESET   = 48'h0000_0000_1000;
  localparam logic [AXIS_REG_WIDTH-1:0] AXIS_TWO_RESET   = 48'h0000_1000_0000;
  localparam logic [AXIS_REG_WIDTH-1:0] AXIS_THREE_RESET = 48'h1000_0000_0000;

  typedef logic [AXIS_REG_WIDTH-1:0] axis_reg_t;
  typedef axis_reg_t [NUM_AXES-1:0] axes_t;

  // Pick component c (x, y, z) of axis a
  function automatic logic signed [AXIS_COMP_WIDTH-1:0] axis_comp(axes_t axes, int a, int c);
    return $signed(axes[a][AXIS_COMP_WIDTH*c +: AXIS_COMP_WIDTH]);
  endfunction

endpackage

`default_nettype wire

[rtl/obef_front.sv]
`default_nettype none

module obef_front
  import obef_pkg::*;
#(
  parameter int COORD_WIDTH = 24,
  parameter int ENTRY_WIDTH = 3 * (COORD_WIDTH + 18) + 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  axes_t                         axes_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [COORD_WIDTH-1:0] point_x_i,
  input  logic signed [COORD_WIDTH-1:0] point_y_i,
  input  logic signed [COORD_WIDTH-1:0] point_z_i,
  input  logic                          final_point_i,
  output logic                          push_o,
  output logic [ENTRY_WIDTH-1:0]        entry_o,
  input  logic                          full_i
);

  localparam int MW = COORD_WIDTH + AXIS_COMP_WIDTH;
  localparam int PW = COORD_WIDTH + 18;

  logic signed [COORD_WIDTH-1:0] pt_w [3];
  logic signed [MW-1:0]          prod_q [3][3];
  logic                          final_a_q;
  logic                          va_q;
  logic signed [PW-1:0]          proj_q [3];
  logic                          final_b_q;
  logic                          vb_q;
  logic                          en_a;
  logic                          en_b;

  // Advance each stage when it is empty or the next one takes its beat
  assign en_b       = !vb_q || !full_i;
  assign en_a       = !va_q || en_b;
  assign in_ready_o = en_a;
  assign push_o     = vb_q && !full_i;

  assign pt_w[0] = point_x_i;
  assign pt_w[1] = point_y_i;
  assign pt_w[2] = point_z_i;

  // Hold stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else begin
      if (en_a) va_q <= in_valid_i;
      if (en_b) vb_q <= va_q;
    end
  end

  // Stage A: component products, stage B: dot products
  always_ff @(posedge clk_i) begin
    if (en_a) begin
      final_a_q <= final_point_i;
      for (int a = 0; a < 3; a++) begin
        for (int c = 0; c < 3; c++) begin
          prod_q[a][c] <= axis_comp(axes_i, a, c) * pt_w[c];
        end
      end
    end
    if (en_b) begin
      final_b_q <= final_a_q;
      for (int a = 0; a < 3; a++) begin
        proj_q[a] <= PW'(prod_q[a][0]) + PW'(prod_q[a][1]) + PW'(prod_q[a][2]);
      end
    end
  end

  assign entry_o = {final_b_q, proj_q[2], proj_q[1], proj_q[0]};

endmodule

`default_nettype wire

[rtl/obef_queue.sv]
`default_nettype none

module obef_queue #(
  parameter int WIDTH = 127,
  parameter int DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  // DEPTH is a power of two so the pointers wrap by themselves
  localparam int AW   = $clog2(DEPTH);
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q;
  logic [AW-1:0]    rd_ptr_q;
  logic [CNTW-1:0]  count_q;

  assign full_o  = (count_q == CNTW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign data_o  = slot_q[rd_ptr_q];

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (push_i && !pop_i)      count_q <= count_q + 1'b1;
      else if (pop_i && !push_i) count_q <= count_q - 1'b1;
    end
  end

  // Store the pushed beat
  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_ptr_q] <= data_i;
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("queue pushed while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("queue popped while empty");

  a_count_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> (count_q == CNTW'($past(count_q) + 1'b1)))
    else $error("queue count did not follow a push");

endmodule

`default_nettype wire

[rtl/obef_back.sv]
`default_nettype none

module obef_back
  import obef_pkg::*;
#(
  parameter int COORD_WIDTH        = 24,
  parameter int AXIS_FRACTION_BITS = 12,
  parameter int ENTRY_WIDTH        = 3 * (COORD_WIDTH + 18) + 1
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  axes_t                          axes_i,
  input  logic [ENTRY_WIDTH-1:0]         entry_i,
  input  logic                           empty_i,
  output logic                           pop_o,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [EXTENT_WIDTH-1:0]        box_width_o,
  output logic [EXTENT_WIDTH-1:0]        box_height_o,
  output logic [EXTENT_WIDTH-1:0]        box_depth_o,
  output logic signed [CENTER_WIDTH-1:0] center_x_o,
  output logic signed [CENTER_WIDTH-1:0] center_y_o,
  output logic signed [CENTER_WIDTH-1:0] center_z_o
);

  localparam int F    = AXIS_FRACTION_BITS;
  localparam int PW   = COORD_WIDTH + 18;          // projection
  localparam int SW   = PW + 1;                    // low plus high
  localparam int HW   = SW - 16;                   // high part of the sum
  localparam int XW   = (PW + 2 > 31) ? PW + 2 : 31;
  localparam int TW   = COORD_WIDTH + 38;
  localparam int TXW  = (TW > 2 * F + 34) ? TW : 2 * F + 34;
  localparam int PHW  = HW + AXIS_COMP_WIDTH;
  localparam int PLW  = 17 + AXIS_COMP_WIDTH;

  localparam logic [XW-1:0]         EXT_HALF = XW'(1) << (F - 1);
  localparam logic [XW-1:0]         EXT_MAX  = XW'(EXTENT_MAX);
  localparam logic signed [TXW-1:0] CTR_HALF = TXW'(1) <<< (2 * F);
  localparam logic signed [TXW-1:0] CTR_MAX  = TXW'(64'sh7FFF_FFFF);
  localparam logic signed [TXW-1:0] CTR_MIN  = TXW'(-(64'sd2147483648));

  logic signed [PW-1:0]  proj_w [3];
  logic                  final_w;
  logic                  pop;
  logic                  adv;

  logic                  first_q;
  logic signed [PW-1:0]  low_q [3];
  logic signed [PW-1:0]  high_q [3];
  logic signed [PW-1:0]  low_n [3];
  logic signed [PW-1:0]  high_n [3];

  logic                  v1_q, v2_q, v3_q, v4_q, v5_q;
  logic signed [PW-1:0]  lo1_q [3];
  logic signed [PW-1:0]  hi1_q [3];
  logic signed [SW-1:0]  s2_q [3];
  logic [EXTENT_WIDTH-1:0] ext_d [3];
  logic [EXTENT_WIDTH-1:0] ext2_q [3];
  logic [EXTENT_WIDTH-1:0] ext3_q [3];
  logic [EXTENT_WIDTH-1:0] ext4_q [3];
  logic signed [PHW-1:0] ph_q [3][3];
  logic signed [PLW-1:0] pl_q [3][3];
  logic signed [HW-1:0]  sh_w [3];
  logic signed [16:0]    sl_w [3];
  logic signed [TXW-1:0] tot_q [3];
  logic signed [CENTER_WIDTH-1:0] ctr_d [3];

  // Unpack the queue head
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      proj_w[a] = $signed(entry_i[a*PW +: PW]);
    end
  end
  assign final_w = entry_i[3*PW];

  // The finish pipeline moves as one; only a last point needs room in it
  assign adv   = !v5_q || out_ready_i;
  assign pop   = !empty_i && (!final_w || adv);
  assign pop_o = pop;

  // Update the extremes; a seeding point overwrites both
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      if (first_q) begin
        low_n[a]  = proj_w[a];
        high_n[a] = proj_w[a];
      end else begin
        low_n[a]  = (proj_w[a] < low_q[a])  ? proj_w[a] : low_q[a];
        high_n[a] = (proj_w[a] > high_q[a]) ? proj_w[a] : high_q[a];
      end
    end
  end

  // Round and saturate the extents
  always_comb begin
    logic signed [PW:0] diff;
    logic [XW-1:0]      rnd;
    for (int a = 0; a < 3; a++) begin
      diff = (PW + 1)'(hi1_q[a]) - (PW + 1)'(lo1_q[a]);
      rnd  = (XW'($unsigned(diff)) + EXT_HALF) >> F;
      ext_d[a] = (rnd > EXT_MAX) ? EXTENT_MAX : rnd[EXTENT_WIDTH-1:0];
    end
  end

  // Split each sum into a signed high part and an unsigned low 16 bits
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      sh_w[a] = $signed(s2_q[a][SW-1:16]);
      sl_w[a] = $signed({1'b0, s2_q[a][15:0]});
    end
  end

  // Round and saturate the centers
  always_comb begin
    logic signed [TXW-1:0] r;
    for (int c = 0; c < 3; c++) begin
      r = (tot_q[c] + CTR_HALF) >>> (2 * F + 1);
      if (r > CTR_MAX)      ctr_d[c] = CTR_MAX[CENTER_WIDTH-1:0];
      else if (r < CTR_MIN) ctr_d[c] = CTR_MIN[CENTER_WIDTH-1:0];
      else                  ctr_d[c] = r[CENTER_WIDTH-1:0];
    end
  end

  // Hold set tracking and stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= 1'b1;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      v4_q    <= 1'b0;
      v5_q    <= 1'b0;
    end else begin
      if (pop) first_q <= final_w;
      if (adv) begin
        v1_q <= pop && final_w;
        v2_q <= v1_q;
        v3_q <= v2_q;
        v4_q <= v3_q;
        v5_q <= v4_q;
      end
    end
  end

  // Extremes
  always_ff @(posedge clk_i) begin
    if (pop) begin
      for (int a = 0; a < 3; a++) begin
        low_q[a]  <= low_n[a];
        high_q[a] <= high_n[a];
      end
    end
  end

  // Finish pipeline: capture, sums and extents, products, totals, output
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int a = 0; a < 3; a++) begin
        lo1_q[a]  <= low_n[a];
        hi1_q[a]  <= high_n[a];
        s2_q[a]   <= SW'(lo1_q[a]) + SW'(hi1_q[a]);
        ext2_q[a] <= ext_d[a];
        ext3_q[a] <= ext2_q[a];
        ext4_q[a] <= ext3_q[a];
      end
      for (int c = 0; c < 3; c++) begin
        for (int a = 0; a < 3; a++) begin
          ph_q[c][a] <= axis_comp(axes_i, a, c) * sh_w[a];
          pl_q[c][a] <= axis_comp(axes_i, a, c) * sl_w[a];
        end
        tot_q[c] <= ((TXW'(ph_q[c][0]) + TXW'(ph_q[c][1]) + TXW'(ph_q[c][2])) <<< 16)
                  + TXW'(pl_q[c][0]) + TXW'(pl_q[c][1]) + TXW'(pl_q[c][2]);
      end
      box_width_o  <= ext4_q[0];
      box_height_o <= ext4_q[1];
      box_depth_o  <= ext4_q[2];
      center_x_o   <= ctr_d[0];
      center_y_o   <= ctr_d[1];
      center_z_o   <= ctr_d[2];
    end
  end

  assign out_valid_o = v5_q;

  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(center_x_o)))
    else $error("stalled result changed");

  a_last_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && final_w) |-> adv)
    else $error("last point popped into a stalled pipeline");

  a_seed_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && final_w) |=> first_q)
    else $error("set not restarted after last point");

endmodule

`default_nettype wire

[rtl/oriented_box_extent_fit_core.sv]
// Oriented box extent fit.
// Input channel (in_valid_i / in_ready_o): one 3D point per beat, signed with
// 8 fraction bits, final_point_i marking the last point of a set. One point
// is taken every cycle while the internal four-entry queue has room.
// Output channel (out_valid_o / out_ready_i): one beat per set, carrying the
// three extents along the configured axes and the world-space center.
// From the beat of the last point to its result, the set passes two
// projection stages, the queue write, the extremes update and four finish
// stages (extents and sums, axis products, center totals, rounding).
// A stalled output register holds its beat and freezes the finish pipeline;
// non-last points still drain into the extremes, and only when the queue
// fills does in_ready_o drop.
// Axes are written through cfg_we_i / cfg_index_i / cfg_data_i. The user
// must write them only while no point is in flight; the block itself does
// not enforce this. An index past the third axis is ignored.
// Reset restores unit axes along x, y and z, empties the queue and pipeline
// and makes the next point start a new set.
`default_nettype none

module oriented_box_extent_fit_core
  import obef_pkg::*;
#(
  parameter int COORD_WIDTH        = 24,
  parameter int AXIS_FRACTION_BITS = 12
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [CFG_INDEX_WIDTH-1:0]     cfg_index_i,
  input  logic [AXIS_REG_WIDTH-1:0]      cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic signed [COORD_WIDTH-1:0]  point_x_i,
  input  logic signed [COORD_WIDTH-1:0]  point_y_i,
  input  logic signed [COORD_WIDTH-1:0]  point_z_i,
  input  logic                           final_point_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [EXTENT_WIDTH-1:0]        box_width_o,
  output logic [EXTENT_WIDTH-1:0]        box_height_o,
  output logic [EXTENT_WIDTH-1:0]        box_depth_o,
  output logic signed [CENTER_WIDTH-1:0] center_x_o,
  output logic signed [CENTER_WIDTH-1:0] center_y_o,
  output logic signed [CENTER_WIDTH-1:0] center_z_o
);

  localparam int PW          = COORD_WIDTH + 18;
  localparam int ENTRY_WIDTH = 3 * PW + 1;
  localparam int QUEUE_DEPTH = 4;

  axis_reg_t              axis_one_q;
  axis_reg_t              axis_two_q;
  axis_reg_t              axis_three_q;
  axes_t                  axes;
  logic                   push;
  logic                   full;
  logic                   pop;
  logic                   empty;
  logic [ENTRY_WIDTH-1:0] entry_in;
  logic [ENTRY_WIDTH-1:0] entry_out;

  // Write axis registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      axis_one_q   <= AXIS_ONE_RESET;
      axis_two_q   <= AXIS_TWO_RESET;
      axis_three_q <= AXIS_THREE_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_AXIS_ONE:   axis_one_q   <= cfg_data_i;
        CFG_AXIS_TWO:   axis_two_q   <= cfg_data_i;
        CFG_AXIS_THREE: axis_three_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign axes[0] = axis_one_q;
  assign axes[1] = axis_two_q;
  assign axes[2] = axis_three_q;

  obef_front #(
    .COORD_WIDTH (COORD_WIDTH),
    .ENTRY_WIDTH (ENTRY_WIDTH)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .axes_i        (axes),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .point_x_i     (point_x_i),
    .point_y_i     (point_y_i),
    .point_z_i     (point_z_i),
    .final_point_i (final_point_i),
    .push_o        (push),
    .entry_o       (entry_in),
    .full_i        (full)
  );

  obef_queue #(
    .WIDTH (ENTRY_WIDTH),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (entry_in),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (entry_out),
    .empty_o (empty)
  );

  obef_back #(
    .COORD_WIDTH        (COORD_WIDTH),
    .AXIS_FRACTION_BITS (AXIS_FRACTION_BITS),
    .ENTRY_WIDTH        (ENTRY_WIDTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .axes_i       (axes),
    .entry_i      (entry_out),
    .empty_i      (empty),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .box_width_o  (box_width_o),
    .box_height_o (box_height_o),
    .box_depth_o  (box_depth_o),
    .center_x_o   (center_x_o),
    .center_y_o   (center_y_o),
    .center_z_o   (center_z_o)
  );

endmodule

`default_nettype wire
